@@ rtl/lstb_pkg.sv @@
// ----------------------------------------------------------------------------
// Line sensor top-two bisector: shared package
// Widths, register indexes, the rank hand-off type and the depth table
// that the rank cells, the report pipeline and the top level share.
// ----------------------------------------------------------------------------
package lstb_pkg;

	// Defaults for the top-level parameters.
	localparam int DEF_SENSOR_COUNT = 15;
	localparam int DEF_SAMPLE_BITS  = 12;

	// Fixed field widths.
	localparam int CHANNEL_W   = 4;
	localparam int SAMPLE_W    = 12;
	localparam int BEARING_W   = 9;
	localparam int HALF_DEG_W  = 10;
	localparam int DEPTH_W     = 16;
	localparam int DIFF_W      = 8;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 63;

	// Layout of the configuration words.
	localparam int THR_FIELD_W       = 12;
	localparam int THR_PER_WORD      = 5;
	localparam int BEARINGS_PER_WORD = 7;

	// Number of rank cells in the row: the brightest and the runner-up.
	localparam int RANK_COUNT = 2;

	// Angles in degrees, and a full turn in half degrees.
	localparam int DIFF_MAX      = 180;
	localparam int FULL_TURN     = 360;
	localparam int HALF_DEG_TURN = 720;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_THRESHOLD_A = 3'd0,
		REG_THRESHOLD_B = 3'd1,
		REG_THRESHOLD_C = 3'd2,
		REG_BEARING_A   = 3'd3,
		REG_BEARING_B   = 3'd4,
		REG_BEARING_C   = 3'd5
	} cfg_reg_t;

	// Final ranking of one scan, handed from the cell row to the report.
	typedef struct packed {
		logic                 best_valid;
		logic [CHANNEL_W-1:0] best_channel;
		logic                 second_valid;
		logic [CHANNEL_W-1:0] second_channel;
	} rank_pair_t;

	localparam logic [63:0] Q28_ONE = 64'd268435456;
	localparam logic [63:0] PI_Q28  = 64'd843314857;

	// 1 - cos(diff/2) in Q1.15 by a short series in Q28 fixed point.
	// Only evaluated while the table below is built.
	function automatic logic [DEPTH_W-1:0] depth_of(input int unsigned diff);
		logic [63:0] x;
		logic [63:0] y;
		logic [63:0] r;
		logic [63:0] v;
		x = (64'(diff) * PI_Q28) / 64'd360;
		y = (x * x) >> 28;
		r = Q28_ONE;
		r = Q28_ONE - ((y * r) >> 28) / 64'd132;
		r = Q28_ONE - ((y * r) >> 28) / 64'd90;
		r = Q28_ONE - ((y * r) >> 28) / 64'd56;
		r = Q28_ONE - ((y * r) >> 28) / 64'd30;
		r = Q28_ONE - ((y * r) >> 28) / 64'd12;
		v = ((y * r) >> 28) >> 1;
		v = (v + 64'd4096) >> 13;
		if (v > 64'd32768) begin
			v = 64'd32768;
		end
		return v[DEPTH_W-1:0];
	endfunction

	typedef logic [DEPTH_W-1:0] depth_table_t [DIFF_MAX+1];

	function automatic depth_table_t build_depth_table();
		depth_table_t t;
		for (int i = 0; i <= DIFF_MAX; i++) begin
			t[i] = depth_of(i);
		end
		return t;
	endfunction

	localparam depth_table_t DEPTH_TABLE = build_depth_table();

endpackage

@@ rtl/lstb_rank_cell.sv @@
// ----------------------------------------------------------------------------
// Line sensor top-two bisector: rank cell
// Holds one ranked sample. A candidate that is strictly brighter, that meets
// an empty cell, or that was pushed down from the cell above takes the place
// and pushes the old entry on to the next cell; otherwise the candidate
// itself moves on.
// ----------------------------------------------------------------------------
module lstb_rank_cell #(
	parameter int SAMPLE_BITS = lstb_pkg::DEF_SAMPLE_BITS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           enable,
	input  logic                           clear,
	input  logic                           cand_valid,
	input  logic                           cand_pushed,
	input  logic [SAMPLE_BITS-1:0]         cand_level,
	input  logic [lstb_pkg::CHANNEL_W-1:0] cand_channel,
	output logic                           pass_valid,
	output logic                           pass_pushed,
	output logic [SAMPLE_BITS-1:0]         pass_level,
	output logic [lstb_pkg::CHANNEL_W-1:0] pass_channel,
	output logic                           post_valid,
	output logic [SAMPLE_BITS-1:0]         post_level,
	output logic [lstb_pkg::CHANNEL_W-1:0] post_channel
);
	import lstb_pkg::*;

	logic                   held_valid_q;
	logic [SAMPLE_BITS-1:0] held_level_q;
	logic [CHANNEL_W-1:0]   held_channel_q;
	logic                   take;

	// Equal levels do not displace: the earlier arrival keeps its rank.
	// An entry pushed down from the cell above is never dimmer than what this
	// cell holds, and on equal levels it is the earlier arrival, so it always
	// takes the place.
	assign take = cand_valid
		&& (cand_pushed || !held_valid_q || (cand_level > held_level_q));

	assign pass_pushed = take;

	always_comb begin
		if (take) begin
			post_valid   = 1'b1;
			post_level   = cand_level;
			post_channel = cand_channel;
			pass_valid   = held_valid_q;
			pass_level   = held_level_q;
			pass_channel = held_channel_q;
		end else begin
			post_valid   = held_valid_q;
			post_level   = held_level_q;
			post_channel = held_channel_q;
			pass_valid   = cand_valid;
			pass_level   = cand_level;
			pass_channel = cand_channel;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_valid_q   <= 1'b0;
			held_level_q   <= '0;
			held_channel_q <= '0;
		end else if (enable) begin
			if (clear) begin
				held_valid_q   <= 1'b0;
				held_level_q   <= '0;
				held_channel_q <= '0;
			end else begin
				held_valid_q   <= post_valid;
				held_level_q   <= post_level;
				held_channel_q <= post_channel;
			end
		end
	end

endmodule

@@ rtl/lstb_report.sv @@
// ----------------------------------------------------------------------------
// Line sensor top-two bisector: report pipeline
// Turns the final ranking of a scan into line_seen, the bisector bearing
// and the depth, over three stages with per-stage valid and back-pressure.
// ----------------------------------------------------------------------------
module lstb_report #(
	parameter int SENSOR_COUNT = lstb_pkg::DEF_SENSOR_COUNT
) (
	input  logic                                                clk,
	input  logic                                                arst_n,
	input  logic                                                start,
	input  lstb_pkg::rank_pair_t                                ranks,
	input  logic [SENSOR_COUNT-1:0][lstb_pkg::BEARING_W-1:0]    bearing,
	output logic                                                free,
	output logic                                                result_valid,
	input  logic                                                result_ready,
	output logic                                                line_seen,
	output logic [lstb_pkg::HALF_DEG_W-1:0]                     bisector_half_deg,
	output logic [lstb_pkg::DEPTH_W-1:0]                        line_depth
);
	import lstb_pkg::*;

	localparam int CH_IDX_W = $clog2(SENSOR_COUNT);

	logic                  valid_s1;
	rank_pair_t            ranks_s1;
	logic                  valid_s2;
	logic                  seen_s2;
	logic                  pair_s2;
	logic [HALF_DEG_W-1:0] bis_s2;
	logic [DIFF_W-1:0]     diff_s2;
	logic                  valid_s3;
	logic                  seen_s3;
	logic [HALF_DEG_W-1:0] bis_s3;
	logic [DEPTH_W-1:0]    depth_s3;

	logic                  s3_free;
	logic                  s2_free;
	logic [BEARING_W-1:0]  b1;
	logic [BEARING_W-1:0]  b2;
	logic [BEARING_W-1:0]  diff_raw;
	logic [BEARING_W-1:0]  diff_fold;
	logic                  wrap;
	logic [HALF_DEG_W:0]   sum_w;
	logic [HALF_DEG_W:0]   bis_pair;
	logic [HALF_DEG_W-1:0] bis_next;

	assign s3_free = !valid_s3 || result_ready;
	assign s2_free = !valid_s2 || s3_free;
	assign free    = !valid_s1 || s2_free;

	// Second stage: bearings of both ranks, folded difference and bisector.
	assign b1       = bearing[ranks_s1.best_channel[CH_IDX_W-1:0]];
	assign b2       = bearing[ranks_s1.second_channel[CH_IDX_W-1:0]];
	assign diff_raw = (b1 > b2) ? (b1 - b2) : (b2 - b1);
	assign wrap     = diff_raw > BEARING_W'(DIFF_MAX);
	assign sum_w    = (HALF_DEG_W+1)'(b1) + (HALF_DEG_W+1)'(b2)
		+ (wrap ? (HALF_DEG_W+1)'(FULL_TURN) : '0);
	assign bis_pair = (sum_w >= (HALF_DEG_W+1)'(HALF_DEG_TURN))
		? (sum_w - (HALF_DEG_W+1)'(HALF_DEG_TURN)) : sum_w;
	assign diff_fold = wrap ? (BEARING_W'(FULL_TURN) - diff_raw) : diff_raw;

	always_comb begin
		if (!ranks_s1.best_valid) begin
			bis_next = '0;
		end else if (ranks_s1.second_valid) begin
			bis_next = bis_pair[HALF_DEG_W-1:0];
		end else begin
			bis_next = {b1, 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= start || (valid_s1 && !s2_free);
			valid_s2 <= (valid_s1 && s2_free) || (valid_s2 && !s3_free);
			valid_s3 <= (valid_s2 && s3_free) || (valid_s3 && !result_ready);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			ranks_s1 <= ranks;
		end
		if (valid_s1 && s2_free) begin
			seen_s2 <= ranks_s1.best_valid;
			pair_s2 <= ranks_s1.best_valid && ranks_s1.second_valid;
			bis_s2  <= bis_next;
			diff_s2 <= diff_fold[DIFF_W-1:0];
		end
		if (valid_s2 && s3_free) begin
			seen_s3  <= seen_s2;
			bis_s3   <= bis_s2;
			depth_s3 <= pair_s2 ? DEPTH_TABLE[diff_s2] : '0;
		end
	end

	assign result_valid      = valid_s3;
	assign line_seen         = seen_s3;
	assign bisector_half_deg = bis_s3;
	assign line_depth        = depth_s3;

endmodule

@@ rtl/line_sensor_top_two_bisector.sv @@
// ----------------------------------------------------------------------------
// Line sensor top-two bisector: top level
// Ranks the qualifying samples of a scan and reports the line bearing and
// depth at the end of each scan.
// ----------------------------------------------------------------------------
// The block takes one sample item per clock cycle while sample_ready is
// high, with no dead cycles between scans. A sample counts when it is
// strictly above the threshold of its channel; a row of two rank cells does
// the compare and insert for each sample in the cycle it is accepted, and
// that row sets the one-item-per-cycle rate. The item flagged scan_end is
// ranked first, then the ranking is handed to a three-stage report pipeline
// and the cells start the next scan empty. The edge accepting the scan_end
// item loads the ranking into the first stage; it passes via the second to
// the third, whose valid is result_valid. The report pipeline buffers up to
// three results, so samples keep flowing while a result waits to be taken;
// sample_ready only drops when all three places are full and the result at
// the output is not being taken. Channels at or above SENSOR_COUNT are
// ignored. Thresholds and bearings are written through the configuration
// port; bearings above 359 have 360 taken off as they are written.
module line_sensor_top_two_bisector #(
	parameter int SENSOR_COUNT = lstb_pkg::DEF_SENSOR_COUNT,
	parameter int SAMPLE_BITS  = lstb_pkg::DEF_SAMPLE_BITS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_write,
	input  logic [lstb_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [lstb_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                             sample_valid,
	output logic                             sample_ready,
	input  logic [lstb_pkg::CHANNEL_W-1:0]   channel,
	input  logic [lstb_pkg::SAMPLE_W-1:0]    sample_value,
	input  logic                             scan_end,
	output logic                             result_valid,
	input  logic                             result_ready,
	output logic                             line_seen,
	output logic [lstb_pkg::HALF_DEG_W-1:0]  bisector_half_deg,
	output logic [lstb_pkg::DEPTH_W-1:0]     line_depth
);
	import lstb_pkg::*;

	localparam int CH_IDX_W = $clog2(SENSOR_COUNT);

	// Per-channel thresholds and bearings, unpacked from the config words.
	logic [SENSOR_COUNT-1:0][SAMPLE_BITS-1:0] threshold_q;
	logic [SENSOR_COUNT-1:0][BEARING_W-1:0]   bearing_q;

	logic                   accept;
	logic                   in_range;
	logic [SAMPLE_BITS-1:0] level;
	logic [SAMPLE_BITS-1:0] thr;
	logic                   qualify;
	logic                   report_free;
	rank_pair_t             ranks;

	// Links between neighboring cells; link 0 is the incoming sample.
	logic                   link_valid   [RANK_COUNT];
	logic                   link_pushed  [RANK_COUNT];
	logic [SAMPLE_BITS-1:0] link_level   [RANK_COUNT];
	logic [CHANNEL_W-1:0]   link_channel [RANK_COUNT];

	// Contents of each cell after the current sample is ranked.
	logic                   rank_valid   [RANK_COUNT];
	logic [SAMPLE_BITS-1:0] rank_level   [RANK_COUNT];
	logic [CHANNEL_W-1:0]   rank_channel [RANK_COUNT];

	// Configuration writes land on every channel field of the word written.
	for (genvar i = 0; i < SENSOR_COUNT; i++) begin : g_cfg
		localparam int THR_WORD = i / THR_PER_WORD;
		localparam int THR_LSB  = THR_FIELD_W * (i % THR_PER_WORD);
		localparam int BRG_WORD = i / BEARINGS_PER_WORD;
		localparam int BRG_LSB  = BEARING_W * (i % BEARINGS_PER_WORD);
		localparam logic [CFG_INDEX_W-1:0] THR_REG =
			CFG_INDEX_W'(int'(REG_THRESHOLD_A) + THR_WORD);
		localparam logic [CFG_INDEX_W-1:0] BRG_REG =
			CFG_INDEX_W'(int'(REG_BEARING_A) + BRG_WORD);

		logic [BEARING_W-1:0] brg_field;

		assign brg_field = cfg_data[BRG_LSB +: BEARING_W];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				threshold_q[i] <= '0;
				bearing_q[i]   <= '0;
			end else if (cfg_write) begin
				if (cfg_index == THR_REG) begin
					threshold_q[i] <= cfg_data[THR_LSB +: SAMPLE_BITS];
				end
				if (cfg_index == BRG_REG) begin
					bearing_q[i] <= (brg_field >= BEARING_W'(FULL_TURN))
						? (brg_field - BEARING_W'(FULL_TURN)) : brg_field;
				end
			end
		end
	end

	assign sample_ready = report_free;
	assign accept       = sample_valid && sample_ready;
	assign in_range     = channel < CHANNEL_W'(SENSOR_COUNT);
	assign level        = sample_value[SAMPLE_BITS-1:0];
	assign thr          = threshold_q[channel[CH_IDX_W-1:0]];
	assign qualify      = accept && in_range && (level > thr);

	assign link_valid[0]   = qualify;
	assign link_pushed[0]  = 1'b0;
	assign link_level[0]   = level;
	assign link_channel[0] = channel;

	// The rank row: each cell hands what it does not keep to its neighbor.
	// Whatever falls out of the last cell ranks third and is dropped.
	for (genvar r = 0; r < RANK_COUNT; r++) begin : g_rank
		if (r < RANK_COUNT - 1) begin : g_mid
			lstb_rank_cell #(
				.SAMPLE_BITS (SAMPLE_BITS)
			) u_cell (
				.clk          (clk),
				.arst_n       (arst_n),
				.enable       (accept),
				.clear        (scan_end),
				.cand_valid   (link_valid[r]),
				.cand_pushed  (link_pushed[r]),
				.cand_level   (link_level[r]),
				.cand_channel (link_channel[r]),
				.pass_valid   (link_valid[r+1]),
				.pass_pushed  (link_pushed[r+1]),
				.pass_level   (link_level[r+1]),
				.pass_channel (link_channel[r+1]),
				.post_valid   (rank_valid[r]),
				.post_level   (rank_level[r]),
				.post_channel (rank_channel[r])
			);
		end else begin : g_last
			lstb_rank_cell #(
				.SAMPLE_BITS (SAMPLE_BITS)
			) u_cell (
				.clk          (clk),
				.arst_n       (arst_n),
				.enable       (accept),
				.clear        (scan_end),
				.cand_valid   (link_valid[r]),
				.cand_pushed  (link_pushed[r]),
				.cand_level   (link_level[r]),
				.cand_channel (link_channel[r]),
				.pass_valid   (),
				.pass_pushed  (),
				.pass_level   (),
				.pass_channel (),
				.post_valid   (rank_valid[r]),
				.post_level   (rank_level[r]),
				.post_channel (rank_channel[r])
			);
		end
	end

	assign ranks.best_valid     = rank_valid[0];
	assign ranks.best_channel   = rank_channel[0];
	assign ranks.second_valid   = rank_valid[1];
	assign ranks.second_channel = rank_channel[1];

	lstb_report #(
		.SENSOR_COUNT (SENSOR_COUNT)
	) u_report (
		.clk               (clk),
		.arst_n            (arst_n),
		.start             (accept && scan_end),
		.ranks             (ranks),
		.bearing           (bearing_q),
		.free              (report_free),
		.result_valid      (result_valid),
		.result_ready      (result_ready),
		.line_seen         (line_seen),
		.bisector_half_deg (bisector_half_deg),
		.line_depth        (line_depth)
	);

`ifndef SYNTHESIS
	// The runner-up is only ever filled behind a brighter or equal leader.
	assert property (@(posedge clk) disable iff (!arst_n)
		rank_valid[1] |-> (rank_valid[0] && (rank_level[0] >= rank_level[1])))
		else $error("rank row out of order");

	// Back-pressure on samples only comes from a result waiting at the output.
	assert property (@(posedge clk) disable iff (!arst_n)
		!sample_ready |-> result_valid)
		else $error("sample side stalled without a pending result");

	// A scan with no qualifying sample reports all zeros.
	assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !line_seen) |-> ((bisector_half_deg == '0) && (line_depth == '0)))
		else $error("nonzero result without a line");

	// Reported bearing and depth stay in range.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> ((bisector_half_deg < HALF_DEG_W'(HALF_DEG_TURN))
			&& (line_depth <= DEPTH_W'(32768))))
		else $error("result out of range");
`endif

endmodule

@@ verif/tb_top.sv @@
// ----------------------------------------------------------------------------
// Line sensor top-two bisector: testbench
// Drives sample items through the block and predicts each scan report:
// the two brightest qualifying channels, their bisector bearing and the
// line depth. Directed scans cover the field extremes and corner cases.
// Random scans then run under several register settings, with random
// idling on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;

	import lstb_pkg::*;

	// Indexes past the end of the register list; writes to them are dropped.
	localparam logic [CFG_INDEX_W-1:0] SPARE_INDEX_A = 3'd6;
	localparam logic [CFG_INDEX_W-1:0] SPARE_INDEX_B = 3'd7;

	localparam logic [SAMPLE_W-1:0] LEVEL_MASK = SAMPLE_W'((1 << DEF_SAMPLE_BITS) - 1);
	localparam logic [SAMPLE_W-1:0] LEVEL_MAX  = '1;
	localparam int RANDOM_PHASES    = 6;
	localparam int ITEMS_PER_PHASE  = 75;
	localparam int IDLE_PERCENT     = 18;
	localparam int DRAIN_LIMIT      = 4000;
	localparam int SETTLE_CYCLES    = 8;
	localparam int MAX_REPORTED     = 10;

	// One qualifying sample held by the ranking.
	typedef struct packed {
		logic                 valid;
		logic [SAMPLE_W-1:0]  level;
		logic [CHANNEL_W-1:0] ch;
	} rank_entry_t;

	// One scan report as the block should deliver it.
	typedef struct packed {
		logic                  seen;
		logic [HALF_DEG_W-1:0] bisector;
		logic [DEPTH_W-1:0]    depth;
	} scan_report_t;

	logic                   clk          = 1'b0;
	logic                   arst_n       = 1'b0;
	logic                   cfg_write    = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index    = '0;
	logic [CFG_DATA_W-1:0]  cfg_data     = '0;
	logic                   sample_valid = 1'b0;
	logic                   sample_ready;
	logic [CHANNEL_W-1:0]   channel      = '0;
	logic [SAMPLE_W-1:0]    sample_value = '0;
	logic                   scan_end     = 1'b0;
	logic                   result_valid;
	logic                   result_ready = 1'b0;
	logic                   line_seen;
	logic [HALF_DEG_W-1:0]  bisector_half_deg;
	logic [DEPTH_W-1:0]     line_depth;

	// Copies of the register contents as the block should hold them.
	logic [59:0]           thr_mirror [3];
	logic [CFG_DATA_W-1:0] bear_mirror [3];

	// Ranking of the scan in progress.
	rank_entry_t leader;
	rank_entry_t runner_up;

	scan_report_t pending_reports [$];
	int unsigned  error_count = 0;

	// When set, neither side idles: this gives one long stretch at full rate.
	bit steady_run = 1'b0;

	line_sensor_top_two_bisector u_top (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_write         (cfg_write),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.sample_valid      (sample_valid),
		.sample_ready      (sample_ready),
		.channel           (channel),
		.sample_value      (sample_value),
		.scan_end          (scan_end),
		.result_valid      (result_valid),
		.result_ready      (result_ready),
		.line_seen         (line_seen),
		.bisector_half_deg (bisector_half_deg),
		.line_depth        (line_depth)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// The result side stalls at random, except during the steady stretch.
	always @(posedge clk) begin
		result_ready <= steady_run || ($urandom_range(0, 99) >= IDLE_PERCENT);
	end

	task automatic note_failure(input string what);
		error_count++;
		if (error_count <= MAX_REPORTED) begin
			$display("%s", what);
		end
	endtask

	// Threshold of a channel as the block compares against it.
	function automatic logic [SAMPLE_W-1:0] threshold_for(input logic [CHANNEL_W-1:0] ch);
		int word;
		int slot;
		word = int'(ch) / THR_PER_WORD;
		slot = int'(ch) % THR_PER_WORD;
		return thr_mirror[word][THR_FIELD_W*slot +: THR_FIELD_W] & LEVEL_MASK;
	endfunction

	// Bearing of a channel in degrees, folded into 0..359.
	function automatic int unsigned bearing_for(input logic [CHANNEL_W-1:0] ch);
		int word;
		int slot;
		int unsigned deg;
		word = int'(ch) / BEARINGS_PER_WORD;
		slot = int'(ch) % BEARINGS_PER_WORD;
		deg = bear_mirror[word][BEARING_W*slot +: BEARING_W];
		if (deg >= FULL_TURN) begin
			deg -= FULL_TURN;
		end
		return deg;
	endfunction

	// 1 - cos(gap/2) in Q1.15. The cosine series is evaluated from its
	// highest term down; the divisor of term m is (2m+1)(2m+2).
	function automatic logic [DEPTH_W-1:0] chord_depth(input int unsigned gap);
		logic [63:0] angle;
		logic [63:0] angle_sq;
		logic [63:0] series;
		logic [63:0] half;
		angle = (64'(gap) * PI_Q28) / 64'(FULL_TURN);
		angle_sq = (angle * angle) >> 28;
		series = Q28_ONE;
		for (int m = 5; m >= 1; m--) begin
			series = Q28_ONE - ((angle_sq * series) >> 28) / 64'((2 * m + 1) * (2 * m + 2));
		end
		half = ((angle_sq * series) >> 28) >> 1;
		half = (half + 64'd4096) >> 13;
		if (half > 64'd32768) begin
			half = 64'd32768;
		end
		return half[DEPTH_W-1:0];
	endfunction

	// Ranks one accepted sample and, at the end of a scan, queues the report.
	task automatic rank_sample(input logic [CHANNEL_W-1:0] ch,
			input logic [SAMPLE_W-1:0] raw, input logic last);
		logic [SAMPLE_W-1:0] level;
		scan_report_t        rep;
		int unsigned         lead_deg;
		int unsigned         next_deg;
		int unsigned         gap;
		int unsigned         bis;
		level = raw & LEVEL_MASK;
		// A tie never displaces an earlier sample: only strictly brighter moves up.
		if (int'(ch) < DEF_SENSOR_COUNT && level > threshold_for(ch)) begin
			if (!leader.valid || level > leader.level) begin
				runner_up = leader;
				leader = {1'b1, level, ch};
			end else if (!runner_up.valid || level > runner_up.level) begin
				runner_up = {1'b1, level, ch};
			end
		end
		if (last) begin
			rep = '0;
			if (leader.valid) begin
				rep.seen = 1'b1;
				lead_deg = bearing_for(leader.ch);
				if (runner_up.valid) begin
					next_deg = bearing_for(runner_up.ch);
					gap = (lead_deg > next_deg) ? lead_deg - next_deg : next_deg - lead_deg;
					bis = lead_deg + next_deg;
					// The short way round lies across zero: turn the bisector by half.
					if (gap > DIFF_MAX) begin
						bis += FULL_TURN;
						gap = FULL_TURN - gap;
					end
					bis = bis % HALF_DEG_TURN;
					rep.bisector = HALF_DEG_W'(bis);
					rep.depth = chord_depth(gap);
				end else begin
					rep.bisector = HALF_DEG_W'(2 * lead_deg);
				end
			end
			pending_reports.push_back(rep);
			leader = '0;
			runner_up = '0;
		end
	endtask

	// Results are sampled at the falling edge, where the handshake signals
	// hold the values that the next rising edge will see.
	always @(negedge clk) begin : check_result
		scan_report_t want;
		if (arst_n && result_valid && result_ready) begin
			if (pending_reports.size() == 0) begin
				note_failure($sformatf("unexpected result: seen %0d bisector %0d depth %0d",
					line_seen, bisector_half_deg, line_depth));
			end else begin
				want = pending_reports.pop_front();
				if (line_seen !== want.seen || bisector_half_deg !== want.bisector ||
						line_depth !== want.depth) begin
					note_failure($sformatf(
						"mismatch: seen %0d/%0d bisector %0d/%0d depth %0d/%0d (exp/act)",
						want.seen, line_seen, want.bisector, bisector_half_deg,
						want.depth, line_depth));
				end
			end
		end
	end

	// Sends one sample item. Valid is only lowered on an idle cycle, so an
	// item that follows directly keeps valid high without a glitch.
	task automatic send_sample(input logic [CHANNEL_W-1:0] ch,
			input logic [SAMPLE_W-1:0] level, input logic last);
		while (!steady_run && $urandom_range(0, 99) < IDLE_PERCENT) begin
			sample_valid <= 1'b0;
			@(posedge clk);
		end
		sample_valid <= 1'b1;
		channel <= ch;
		sample_value <= level;
		scan_end <= last;
		@(negedge clk);
		while (!sample_ready) begin
			@(negedge clk);
		end
		rank_sample(ch, level, last);
		@(posedge clk);
	endtask

	// Writes one register and updates the mirror. Write enable is left high
	// so that back-to-back writes need no second assignment in one step.
	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		case (idx)
			REG_THRESHOLD_A: thr_mirror[0] = data[59:0];
			REG_THRESHOLD_B: thr_mirror[1] = data[59:0];
			REG_THRESHOLD_C: thr_mirror[2] = data[59:0];
			REG_BEARING_A:   bear_mirror[0] = data;
			REG_BEARING_B:   bear_mirror[1] = data;
			REG_BEARING_C:   bear_mirror[2] = {54'd0, data[BEARING_W-1:0]};
			default: ;
		endcase
	endtask

	// Writes every register, plus junk to both spare indexes.
	task automatic load_config(input logic [CFG_DATA_W-1:0] thr_a, thr_b, thr_c,
			bear_a, bear_b, bear_c);
		write_reg(REG_THRESHOLD_A, thr_a);
		write_reg(REG_THRESHOLD_B, thr_b);
		write_reg(REG_THRESHOLD_C, thr_c);
		write_reg(SPARE_INDEX_A, CFG_DATA_W'({$urandom, $urandom}));
		write_reg(REG_BEARING_A, bear_a);
		write_reg(REG_BEARING_B, bear_b);
		write_reg(REG_BEARING_C, bear_c);
		write_reg(SPARE_INDEX_B, CFG_DATA_W'({$urandom, $urandom}));
		cfg_write <= 1'b0;
	endtask

	// Waits for every queued report, then lets the pipeline settle so the
	// block is idle before registers change.
	task automatic wait_idle();
		int unsigned waited;
		sample_valid <= 1'b0;
		waited = 0;
		while (pending_reports.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (pending_reports.size() != 0) begin
			note_failure($sformatf("%0d expected results never arrived",
				pending_reports.size()));
			pending_reports.delete();
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Threshold word with random fields in lo..hi; bits above the fields
	// carry junk that the block must drop.
	function automatic logic [CFG_DATA_W-1:0] threshold_word(input int unsigned lo, hi);
		logic [CFG_DATA_W-1:0] w;
		w = CFG_DATA_W'({$urandom, $urandom});
		for (int k = 0; k < THR_PER_WORD; k++) begin
			w[THR_FIELD_W*k +: THR_FIELD_W] = THR_FIELD_W'($urandom_range(hi, lo));
		end
		return w;
	endfunction

	function automatic logic [CFG_DATA_W-1:0] bearing_word(input int unsigned lo, hi);
		logic [CFG_DATA_W-1:0] w;
		w = '0;
		for (int k = 0; k < BEARINGS_PER_WORD; k++) begin
			w[BEARING_W*k +: BEARING_W] = BEARING_W'($urandom_range(hi, lo));
		end
		return w;
	endfunction

	// After reset every threshold and bearing is zero: any nonzero sample
	// qualifies and points straight ahead.
	task automatic test_power_up_defaults();
		send_sample(4'd0, 12'd1, 1'b1);
		send_sample(4'd3, 12'd0, 1'b1);
		wait_idle();
	endtask

	// Thresholds of 1000 with one channel at the top and one at zero;
	// bearings of 30 degrees per channel, with the last three at 359, 400
	// and 511 so that both folded and unfolded large values appear.
	task automatic test_field_extremes();
		logic [CFG_DATA_W-1:0] thr_words [3];
		logic [CFG_DATA_W-1:0] bear_words [3];
		int unsigned t;
		int unsigned b;
		for (int k = 0; k < 3; k++) begin
			thr_words[k] = '0;
			bear_words[k] = '0;
		end
		thr_words[2][62:60] = 3'b111;
		for (int k = 0; k < DEF_SENSOR_COUNT; k++) begin
			t = (k == 10) ? 4095 : ((k == 14) ? 0 : 1000);
			b = (k == 12) ? 359 : ((k == 13) ? 400 : ((k == 14) ? 511 : 30 * k));
			thr_words[k / THR_PER_WORD][THR_FIELD_W*(k % THR_PER_WORD) +: THR_FIELD_W] =
				THR_FIELD_W'(t);
			bear_words[k / BEARINGS_PER_WORD][BEARING_W*(k % BEARINGS_PER_WORD) +: BEARING_W] =
				BEARING_W'(b);
		end
		bear_words[2][62:BEARING_W] = '1;
		load_config(thr_words[0], thr_words[1], thr_words[2],
			bear_words[0], bear_words[1], bear_words[2]);
		// Full-scale tie, bearings 210 degrees apart.
		send_sample(4'd0, LEVEL_MAX, 1'b0);
		send_sample(4'd7, LEVEL_MAX, 1'b1);
		// A scan holding only a channel past the sensor count.
		send_sample(4'd15, LEVEL_MAX, 1'b1);
		// Full-scale sample against a full-scale threshold does not count.
		send_sample(4'd10, LEVEL_MAX, 1'b1);
		// Zero threshold: zero does not qualify, one does.
		send_sample(4'd14, 12'd0, 1'b1);
		send_sample(4'd14, 12'd1, 1'b1);
		// Bearings exactly 180 apart, equal levels in reverse channel order.
		send_sample(4'd0, 12'd0, 1'b0);
		send_sample(4'd6, 12'd1001, 1'b0);
		send_sample(4'd0, 12'd1001, 1'b1);
		wait_idle();
	endtask

	// Corner cases of ranking and bearing, under the directed settings.
	task automatic test_special_scans();
		// Single channel.
		send_sample(4'd3, 12'd2000, 1'b1);
		// Folded bearing paired with 359: the short way round crosses zero.
		send_sample(4'd13, 12'd3000, 1'b0);
		send_sample(4'd12, 12'd2000, 1'b1);
		// Level equal to the threshold: no line.
		send_sample(4'd1, 12'd1000, 1'b1);
		// The same channel twice takes both ranks.
		send_sample(4'd5, 12'd2000, 1'b0);
		send_sample(4'd5, 12'd3000, 1'b1);
		// Four qualifiers: later ones displace and drop earlier ones.
		send_sample(4'd3, 12'd1100, 1'b0);
		send_sample(4'd9, 12'd1300, 1'b0);
		send_sample(4'd6, 12'd1200, 1'b0);
		send_sample(4'd11, 12'd1250, 1'b1);
		// Scan end carried by an ignored channel still reports.
		send_sample(4'd2, 12'd1500, 1'b0);
		send_sample(4'd15, LEVEL_MAX, 1'b1);
		// Scan end carried by a sample below its threshold.
		send_sample(4'd4, 12'd1400, 1'b0);
		send_sample(4'd8, 12'd500, 1'b1);
		wait_idle();
	endtask

	// Random scans under six settings. Most items form scans of qualifying
	// and near-threshold samples; the rest are noise on any channel.
	task automatic test_random_scans();
		int unsigned         sent;
		int unsigned         scan_len;
		logic [CHANNEL_W-1:0] ch;
		logic [SAMPLE_W-1:0]  level;
		logic [SAMPLE_W-1:0]  prev_level;
		logic [SAMPLE_W-1:0]  thr;
		prev_level = '0;
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			case (phase)
				1: load_config('1, '1, '1, '1, '1, '1);
				2: load_config('0, '0, '0, '0, '0, '0);
				3: load_config(threshold_word(0, 2500), threshold_word(0, 2500),
					threshold_word(0, 2500), bearing_word(0, 359), bearing_word(0, 359),
					bearing_word(0, 359));
				4: load_config(threshold_word(0, 4095), threshold_word(0, 4095),
					threshold_word(0, 4095), CFG_DATA_W'({$urandom, $urandom}),
					CFG_DATA_W'({$urandom, $urandom}), CFG_DATA_W'({$urandom, $urandom}));
				default: load_config(threshold_word(0, 2500), threshold_word(0, 2500),
					threshold_word(0, 2500), bearing_word(0, 511), bearing_word(0, 511),
					CFG_DATA_W'({$urandom, $urandom}));
			endcase
			steady_run = (phase == 3);
			sent = 0;
			while (sent < ITEMS_PER_PHASE) begin
				if ($urandom_range(0, 99) < 15) begin
					send_sample(CHANNEL_W'($urandom_range(0, 15)), SAMPLE_W'($urandom),
						1'($urandom_range(0, 1)));
					sent++;
				end else begin
					scan_len = $urandom_range(1, 6);
					for (int k = 0; k < scan_len; k++) begin
						ch = CHANNEL_W'($urandom_range(0, DEF_SENSOR_COUNT - 1));
						thr = threshold_for(ch);
						case ($urandom_range(0, 5))
							0: level = SAMPLE_W'($urandom);
							1: level = (thr == LEVEL_MAX) ? thr : thr + 1'b1;
							2: level = thr;
							3: level = LEVEL_MAX;
							4: level = prev_level;
							default: level = SAMPLE_W'($urandom_range(4095, thr));
						endcase
						prev_level = level;
						send_sample(ch, level, k == scan_len - 1);
						sent++;
					end
				end
			end
			// Noise may leave a scan open; close it before the settings change.
			send_sample(CHANNEL_W'($urandom_range(0, 15)), SAMPLE_W'($urandom), 1'b1);
			steady_run = 1'b0;
			wait_idle();
		end
	endtask

	initial begin
		for (int k = 0; k < 3; k++) begin
			thr_mirror[k] = '0;
			bear_mirror[k] = '0;
		end
		leader = '0;
		runner_up = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_power_up_defaults();
		test_field_extremes();
		test_special_scans();
		test_random_scans();
		wait_idle();
		if (error_count == 0) begin
			$display("PASS line_sensor_top_two_bisector");
		end else begin
			$display("FAIL line_sensor_top_two_bisector");
		end
		$finish;
	end

	// Far beyond the slowest correct run of this stimulus.
	initial begin
		#2_000_000;
		$display("FAIL line_sensor_top_two_bisector");
		$finish;
	end

endmodule

@@ line_sensor_top_two_bisector.f @@
rtl/lstb_pkg.sv
rtl/lstb_rank_cell.sv
rtl/lstb_report.sv
rtl/line_sensor_top_two_bisector.sv
verif/tb_top.sv
